// ===== rtl/core/mcssg_pkg.sv =====
// Shared types, widths and constants of the motor current / speed stall guard.
// No dependencies; every other file of the block but mcssg_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mcssg_pkg;

  // Channel count served by the block
  localparam int CHANNELS = 4;

  // Field widths
  localparam int CH_W       = 2;
  localparam int CUR_W      = 10;
  localparam int SPD_W      = 7;
  localparam int SPD8_W     = 8;
  localparam int LED_W      = 4;
  localparam int ST_W       = 2;
  localparam int TMR_W      = 16;
  localparam int PC_W       = 8;
  localparam int THR_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Per-channel entry slots, one per channel code
  localparam int CH_SLOTS = 1 << CH_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STALL_CURRENT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LED_FAULT_CURRENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_TICKS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_END_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BAND       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_PERSIST    = 3'd5;

  // Configuration defaults
  localparam logic [CUR_W-1:0] RST_STALL_CURRENT     = 10'd500;
  localparam logic [CUR_W-1:0] RST_LED_FAULT_CURRENT = 10'd300;
  localparam logic [TMR_W-1:0] RST_BOOST_TICKS       = 16'd150;
  localparam logic [TMR_W-1:0] RST_PAUSE_END_TICKS   = 16'd250;
  localparam logic [CUR_W-1:0] RST_FILTER_BAND       = 10'd4;
  localparam logic [PC_W-1:0]  RST_FILTER_PERSIST    = 8'd20;

  // Stall state codes
  localparam logic [ST_W-1:0] ST_NORMAL = 2'd0;
  localparam logic [ST_W-1:0] ST_PAUSE  = 2'd1;
  localparam logic [ST_W-1:0] ST_BOOST  = 2'd2;

  // Speed band limits and fixed speeds
  localparam logic [SPD8_W-1:0] BAND1_MAX       = 8'd45;
  localparam logic [SPD8_W-1:0] BAND3_MIN       = 8'd65;
  localparam logic [SPD8_W-1:0] BOOST_MIN_SPEED = 8'd99;
  localparam logic [SPD8_W-1:0] TARGET_HIGH     = 8'd97;
  localparam logic [SPD8_W-1:0] SPEED_CAP       = 8'd99;
  localparam logic [SPD8_W-1:0] SPEED_MAX       = 8'd100;
  localparam logic [SPD_W-1:0]  SPEED_BOOST     = 7'd100;

  typedef struct packed {
    logic [CUR_W-1:0] stall_current;
    logic [CUR_W-1:0] led_fault_current;
    logic [TMR_W-1:0] boost_ticks;
    logic [TMR_W-1:0] pause_end_ticks;
    logic [CUR_W-1:0] filter_band;
    logic [PC_W-1:0]  filter_persist;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [CUR_W-1:0] raw_current;
    logic [SPD_W-1:0] target_speed;
    logic [SPD_W-1:0] present_speed;
    logic             channel_commanded;
    logic             display_mute;
  } item_t;

  typedef struct packed {
    logic [SPD_W-1:0] speed_out;
    logic [LED_W-1:0] led_on_mask;
    logic [LED_W-1:0] led_blink_mask;
    logic [ST_W-1:0]  stall_state_out;
    logic             pause_active;
  } result_t;

  // One channel entry as stored in the state memory
  typedef struct packed {
    logic [CUR_W-1:0] fcur;
    logic [PC_W-1:0]  pcount;
    logic [ST_W-1:0]  state;
    logic [TMR_W-1:0] timer;
  } entry_t;

  localparam int ENTRY_W = CUR_W + PC_W + ST_W + TMR_W;

endpackage

`default_nettype wire

// ===== rtl/core/mcssg_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on mcssg_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mcssg_in_if import mcssg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  channel;
  logic [CUR_W-1:0] raw_current;
  logic [SPD_W-1:0] target_speed;
  logic [SPD_W-1:0] present_speed;
  logic             channel_commanded;
  logic             display_mute;

  modport source (
    output valid, channel, raw_current, target_speed, present_speed,
           channel_commanded, display_mute,
    input  ready
  );
  modport sink (
    input  valid, channel, raw_current, target_speed, present_speed,
           channel_commanded, display_mute,
    output ready
  );
endinterface

interface mcssg_out_if import mcssg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SPD_W-1:0] speed_out;
  logic [LED_W-1:0] led_on_mask;
  logic [LED_W-1:0] led_blink_mask;
  logic [ST_W-1:0]  stall_state_out;
  logic             pause_active;

  modport source (
    output valid, speed_out, led_on_mask, led_blink_mask, stall_state_out,
           pause_active,
    input  ready
  );
  modport sink (
    input  valid, speed_out, led_on_mask, led_blink_mask, stall_state_out,
           pause_active,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/mcssg_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mcssg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                        wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one word and read one word, with the read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/mcssg_update.sv =====
// Per-item update of one channel: current filter, speed bands, LEDs, stall FSM.
// Depends on mcssg_pkg; purely combinational, used by the top level.
`timescale 1ns / 1ps
`default_nettype none

module mcssg_update import mcssg_pkg::*; (
  input  wire item_t            item_i,
  input  wire entry_t           entry_i,
  input  wire cfg_t             cfg_i,
  input  wire logic             pause_i,
  input  wire logic [LED_W-1:0] led_on_i,
  input  wire logic [LED_W-1:0] led_blink_i,
  output entry_t                entry_o,
  output logic                  pause_o,
  output logic [LED_W-1:0]      led_on_o,
  output logic [LED_W-1:0]      led_blink_o,
  output result_t               result_o,
  output logic                  ch_ok_o
);

  // One band step: raise above the upper line, lower at or below the lower line
  function automatic logic [SPD8_W-1:0] band_step(
    input logic [SPD8_W-1:0] s,
    input logic [CUR_W-1:0]  cur,
    input logic [2:0]        up_mul,
    input logic [2:0]        up_add,
    input logic [2:0]        dn_mul,
    input logic [2:0]        dn_add
  );
    logic [THR_W-1:0] up_thr;
    logic [THR_W-1:0] dn_thr;
    logic [THR_W-1:0] cur_x;
    up_thr = THR_W'(up_add) + THR_W'(up_mul) * THR_W'(s);
    dn_thr = THR_W'(dn_add) + THR_W'(dn_mul) * THR_W'(s);
    cur_x  = THR_W'(cur);
    if (cur_x > up_thr) begin
      band_step = s + 8'd1;
    end else if (cur_x <= dn_thr) begin
      band_step = s - 8'd1;
    end else begin
      band_step = s;
    end
  endfunction

  logic              ch_ok;
  logic [CUR_W-1:0]  diff;
  logic [CUR_W-1:0]  fc;
  logic [PC_W-1:0]   pc;
  logic [SPD8_W-1:0] spd;
  logic [SPD8_W-1:0] tgt;
  logic [LED_W-1:0]  bit_mask;
  logic [LED_W-1:0]  led_on;
  logic [LED_W-1:0]  led_blink;
  logic              fault;
  logic [ST_W-1:0]   st;
  logic [TMR_W-1:0]  tmr;
  logic              pause;
  logic [SPD_W-1:0]  speed_set;

  always_comb begin
    ch_ok = 32'(item_i.channel) < CHANNELS;

    // Persistence filter on the raw current
    diff = (item_i.raw_current >= entry_i.fcur) ? item_i.raw_current - entry_i.fcur
                                                : entry_i.fcur - item_i.raw_current;
    fc = entry_i.fcur;
    pc = entry_i.pcount;
    if (diff > cfg_i.filter_band) begin
      pc = pc + 8'd1;
    end else begin
      pc = '0;
    end
    if (pc > cfg_i.filter_persist) begin
      pc = '0;
      fc = item_i.raw_current;
    end

    // Speed bands, one after another, with 8-bit wrap
    spd = SPD8_W'(item_i.present_speed);
    if (spd <= BAND1_MAX) begin
      spd = band_step(spd, fc, 3'd4, 3'd3, 3'd3, 3'd3);
    end
    if (spd > BAND1_MAX && spd < BAND3_MIN) begin
      spd = band_step(spd, fc, 3'd4, 3'd6, 3'd3, 3'd6);
    end
    if (spd >= BAND3_MIN) begin
      spd = band_step(spd, fc, 3'd5, 3'd6, 3'd4, 3'd6);
    end

    // LED bits of this channel
    bit_mask  = LED_W'(1) << item_i.channel;
    fault     = (fc > cfg_i.led_fault_current) || (entry_i.state == ST_PAUSE);
    led_on    = led_on_i;
    led_blink = led_blink_i;
    if (item_i.channel_commanded && !fault) begin
      led_on    = led_on | bit_mask;
      led_blink = led_blink & ~bit_mask;
    end else if (item_i.channel_commanded) begin
      led_on    = led_on & ~bit_mask;
      led_blink = led_blink | bit_mask;
    end else begin
      led_on    = led_on & ~bit_mask;
      led_blink = led_blink & ~bit_mask;
    end
    if (item_i.display_mute) begin
      led_on    = led_on & ~bit_mask;
      led_blink = led_blink & ~bit_mask;
    end

    // Stall entry and exit
    st    = entry_i.state;
    tmr   = entry_i.timer;
    pause = pause_i;
    if (fc > cfg_i.stall_current && spd >= BOOST_MIN_SPEED) begin
      st = ST_BOOST;
    end else if (fc <= cfg_i.stall_current && !pause_i) begin
      st = ST_NORMAL;
    end

    // Clamp against the target
    tgt = SPD8_W'(item_i.target_speed);
    if (tgt == '0) begin
      spd = '0;
    end else if (spd < tgt || spd > SPEED_MAX) begin
      spd = tgt;
    end
    if (tgt > TARGET_HIGH) begin
      spd = SPEED_CAP;
    end

    // Advance the stall timer and state
    case (st)
      ST_BOOST: begin
        tmr = tmr + 16'd1;
        if (tmr >= cfg_i.boost_ticks) begin
          st    = ST_PAUSE;
          pause = 1'b1;
        end
      end
      ST_PAUSE: begin
        tmr = tmr + 16'd1;
        if (tmr >= cfg_i.pause_end_ticks) begin
          st    = ST_NORMAL;
          pause = 1'b0;
        end
      end
      ST_NORMAL: begin
        tmr = '0;
      end
      default: ;
    endcase

    // Speed to apply
    case (st)
      ST_PAUSE:  speed_set = '0;
      ST_NORMAL: speed_set = spd[SPD_W-1:0];
      ST_BOOST:  speed_set = SPEED_BOOST;
      default:   speed_set = '0;
    endcase

    // Drive outputs; a channel outside the served range changes nothing
    ch_ok_o = ch_ok;
    if (ch_ok) begin
      entry_o.fcur   = fc;
      entry_o.pcount = pc;
      entry_o.state  = st;
      entry_o.timer  = tmr;
      pause_o        = pause;
      led_on_o       = led_on;
      led_blink_o    = led_blink;
      result_o.speed_out       = speed_set;
      result_o.stall_state_out = st;
    end else begin
      entry_o     = entry_i;
      pause_o     = pause_i;
      led_on_o    = led_on_i;
      led_blink_o = led_blink_i;
      result_o.speed_out       = '0;
      result_o.stall_state_out = ST_NORMAL;
    end
    result_o.led_on_mask    = led_on_o;
    result_o.led_blink_mask = led_blink_o;
    result_o.pause_active   = pause_o;
  end

endmodule

`default_nettype wire

// ===== rtl/core/motor_current_speed_stall_guard.sv =====
// Motor current / speed stall guard, top level.
// Each item passes the stage 1 item register and then the output register.
// Throughput: one item per cycle while the result port takes results, with a
// read-modify-write of the per-channel state memory and a bypass for back-to-back channels.
// Reset: config registers take their defaults; per-entry valid bits make every
// channel entry read as zero, so no clearing pass runs and items are taken at once.
`timescale 1ns / 1ps
`default_nettype none

module motor_current_speed_stall_guard import mcssg_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  mcssg_in_if.sink                   in_i,
  mcssg_out_if.source                out_o
);

  cfg_t             cfg_q;
  logic             s1_valid_q;
  item_t            s1_item_q;
  logic             out_valid_q;
  result_t          out_data_q;
  logic             pause_q;
  logic [LED_W-1:0] led_on_q;
  logic [LED_W-1:0] led_blink_q;
  logic [CH_SLOTS-1:0] ent_valid_q;
  logic             byp_valid_q;
  logic [CH_W-1:0]  byp_ch_q;
  entry_t           byp_data_q;

  logic             in_ready;
  logic             in_accept;
  logic             out_free;
  logic             s1_fire;
  logic [CH_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic             ram_we;
  entry_t           entry_cur;
  entry_t           entry_d;
  logic             pause_d;
  logic [LED_W-1:0] led_on_d;
  logic [LED_W-1:0] led_blink_d;
  result_t          result_d;
  logic             ch_ok;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stall_current     <= RST_STALL_CURRENT;
      cfg_q.led_fault_current <= RST_LED_FAULT_CURRENT;
      cfg_q.boost_ticks       <= RST_BOOST_TICKS;
      cfg_q.pause_end_ticks   <= RST_PAUSE_END_TICKS;
      cfg_q.filter_band       <= RST_FILTER_BAND;
      cfg_q.filter_persist    <= RST_FILTER_PERSIST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STALL_CURRENT:     cfg_q.stall_current     <= cfg_wdata_i[CUR_W-1:0];
        REG_LED_FAULT_CURRENT: cfg_q.led_fault_current <= cfg_wdata_i[CUR_W-1:0];
        REG_BOOST_TICKS:       cfg_q.boost_ticks       <= cfg_wdata_i[TMR_W-1:0];
        REG_PAUSE_END_TICKS:   cfg_q.pause_end_ticks   <= cfg_wdata_i[TMR_W-1:0];
        REG_FILTER_BAND:       cfg_q.filter_band       <= cfg_wdata_i[CUR_W-1:0];
        REG_FILTER_PERSIST:    cfg_q.filter_persist    <= cfg_wdata_i[PC_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage 1 moves on when the output register is free
  assign out_free  = !out_valid_q || out_o.ready;
  assign s1_fire   = s1_valid_q && out_free;
  assign in_ready  = !s1_valid_q || s1_fire;
  assign in_accept = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Read the entry of the incoming item, or re-read the held one
  assign ram_raddr = in_ready ? in_i.channel : s1_item_q.channel;
  assign ram_we    = s1_fire && ch_ok;

  mcssg_ram #(
    .Width (ENTRY_W),
    .Depth (CH_SLOTS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_item_q.channel),
    .wdata_i (entry_d),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Pick the newest copy of the entry: last write, memory, or reset value
  always_comb begin
    if (byp_valid_q && byp_ch_q == s1_item_q.channel) begin
      entry_cur = byp_data_q;
    end else if (ent_valid_q[s1_item_q.channel]) begin
      entry_cur = entry_t'(ram_rdata);
    end else begin
      entry_cur = '0;
    end
  end

  mcssg_update u_update (
    .item_i      (s1_item_q),
    .entry_i     (entry_cur),
    .cfg_i       (cfg_q),
    .pause_i     (pause_q),
    .led_on_i    (led_on_q),
    .led_blink_i (led_blink_q),
    .entry_o     (entry_d),
    .pause_o     (pause_d),
    .led_on_o    (led_on_d),
    .led_blink_o (led_blink_d),
    .result_o    (result_d),
    .ch_ok_o     (ch_ok)
  );

  // Stage 1 item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q.channel           <= in_i.channel;
      s1_item_q.raw_current       <= in_i.raw_current;
      s1_item_q.target_speed      <= in_i.target_speed;
      s1_item_q.present_speed     <= in_i.present_speed;
      s1_item_q.channel_commanded <= in_i.channel_commanded;
      s1_item_q.display_mute      <= in_i.display_mute;
    end
  end

  // Shared state, entry valid bits and write bypass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_q     <= 1'b0;
      led_on_q    <= '0;
      led_blink_q <= '0;
      ent_valid_q <= '0;
      byp_valid_q <= 1'b0;
      byp_ch_q    <= '0;
    end else begin
      if (s1_fire) begin
        pause_q     <= pause_d;
        led_on_q    <= led_on_d;
        led_blink_q <= led_blink_d;
      end
      if (ram_we) begin
        ent_valid_q[s1_item_q.channel] <= 1'b1;
        byp_valid_q <= 1'b1;
        byp_ch_q    <= s1_item_q.channel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      byp_data_q <= entry_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_data_q <= result_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.speed_out       = out_data_q.speed_out;
  assign out_o.led_on_mask     = out_data_q.led_on_mask;
  assign out_o.led_blink_mask  = out_data_q.led_blink_mask;
  assign out_o.stall_state_out = out_data_q.stall_state_out;
  assign out_o.pause_active    = out_data_q.pause_active;

endmodule

`default_nettype wire

// ===== test/mcssg_result_checker.sv =====
// Result checker for the motor current / speed stall guard: watches the item,
// result and register-write ports, predicts every result and compares it.
// Depends on mcssg_pkg and the channel interfaces in mcssg_if.
`timescale 1ns / 1ps

module mcssg_result_checker import mcssg_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  mcssg_in_if                        item_mon,
  mcssg_out_if                       result_mon,
  output int                         mismatches_o,
  output int                         outstanding_o
);

  // Shadow copy of the registers and of the per-channel guard state
  cfg_t              cfg_regs;
  logic [CUR_W-1:0]  filt_current [CHANNELS];
  logic [PC_W-1:0]   persist_cnt  [CHANNELS];
  logic [ST_W-1:0]   stall_st     [CHANNELS];
  logic [TMR_W-1:0]  stall_tmr    [CHANNELS];
  logic              pause_shadow;
  logic [LED_W-1:0]  led_on;
  logic [LED_W-1:0]  led_blink;

  result_t awaited_results [$];

  // Nudge the speed by one step inside one current-per-speed band
  function automatic logic [SPD8_W-1:0] band_step(logic [SPD8_W-1:0] s, int unsigned cur,
                                                  int unsigned up_mul, int unsigned up_add,
                                                  int unsigned dn_mul, int unsigned dn_add);
    if (cur > up_add + up_mul * s) return s + 8'd1;
    if (cur <= dn_add + dn_mul * s) return s - 8'd1;
    return s;
  endfunction

  // Advance the guard state by one tick and return the result it produces
  function automatic result_t predict_tick(item_t it);
    result_t           r;
    int unsigned       cur;
    int unsigned       diff;
    int unsigned       ch;
    logic [SPD8_W-1:0] spd;
    logic [LED_W-1:0]  ch_bit;
    logic              fault;
    r = '0;
    ch = it.channel;
    if (ch >= CHANNELS) begin
      r.led_on_mask    = led_on;
      r.led_blink_mask = led_blink;
      r.pause_active   = pause_shadow;
      return r;
    end

    // Adopt the raw current only after a persistent change
    diff = (it.raw_current >= filt_current[ch]) ? it.raw_current - filt_current[ch]
                                                : filt_current[ch] - it.raw_current;
    if (diff > cfg_regs.filter_band) persist_cnt[ch] = persist_cnt[ch] + 8'd1;
    else persist_cnt[ch] = '0;
    if (persist_cnt[ch] > cfg_regs.filter_persist) begin
      persist_cnt[ch]  = '0;
      filt_current[ch] = it.raw_current;
    end
    cur = filt_current[ch];

    // Apply the three bands one after another, 8-bit wrap included
    spd = {1'b0, it.present_speed};
    if (spd <= BAND1_MAX) spd = band_step(spd, cur, 4, 3, 3, 3);
    if (spd > BAND1_MAX && spd < BAND3_MIN) spd = band_step(spd, cur, 4, 6, 3, 6);
    if (spd >= BAND3_MIN) spd = band_step(spd, cur, 5, 6, 4, 6);

    // Update the LED masks; fault uses the stall state from before this tick
    ch_bit = LED_W'(1) << ch;
    fault = (cur > cfg_regs.led_fault_current) || (stall_st[ch] == ST_PAUSE);
    if (it.channel_commanded && !fault) begin
      led_on    = led_on | ch_bit;
      led_blink = led_blink & ~ch_bit;
    end else if (it.channel_commanded) begin
      led_on    = led_on & ~ch_bit;
      led_blink = led_blink | ch_bit;
    end else begin
      led_on    = led_on & ~ch_bit;
      led_blink = led_blink & ~ch_bit;
    end
    if (it.display_mute) begin
      led_on    = led_on & ~ch_bit;
      led_blink = led_blink & ~ch_bit;
    end

    // Enter boost or drop back to normal
    if (cur > cfg_regs.stall_current && spd >= BOOST_MIN_SPEED) stall_st[ch] = ST_BOOST;
    else if (cur <= cfg_regs.stall_current && !pause_shadow) stall_st[ch] = ST_NORMAL;

    // Clamp against the target
    if (it.target_speed == '0) spd = '0;
    else if (spd < it.target_speed || spd > SPEED_MAX) spd = {1'b0, it.target_speed};
    if (it.target_speed > TARGET_HIGH) spd = SPEED_CAP;

    // Run the boost / pause timer
    case (stall_st[ch])
      ST_BOOST: begin
        stall_tmr[ch] = stall_tmr[ch] + 16'd1;
        if (stall_tmr[ch] >= cfg_regs.boost_ticks) begin
          stall_st[ch] = ST_PAUSE;
          pause_shadow = 1'b1;
        end
      end
      ST_PAUSE: begin
        stall_tmr[ch] = stall_tmr[ch] + 16'd1;
        if (stall_tmr[ch] >= cfg_regs.pause_end_ticks) begin
          stall_st[ch] = ST_NORMAL;
          pause_shadow = 1'b0;
        end
      end
      ST_NORMAL: stall_tmr[ch] = '0;
      default: ;
    endcase

    case (stall_st[ch])
      ST_NORMAL: r.speed_out = spd[SPD_W-1:0];
      ST_BOOST:  r.speed_out = SPEED_BOOST;
      default:   r.speed_out = '0;
    endcase
    r.led_on_mask     = led_on;
    r.led_blink_mask  = led_blink;
    r.stall_state_out = stall_st[ch];
    r.pause_active    = pause_shadow;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches_o++;
    end
  endfunction

  // Track register writes, compare results, then predict newly accepted items
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    item_t   it;
    if (!rst_ni) begin
      cfg_regs.stall_current     = RST_STALL_CURRENT;
      cfg_regs.led_fault_current = RST_LED_FAULT_CURRENT;
      cfg_regs.boost_ticks       = RST_BOOST_TICKS;
      cfg_regs.pause_end_ticks   = RST_PAUSE_END_TICKS;
      cfg_regs.filter_band       = RST_FILTER_BAND;
      cfg_regs.filter_persist    = RST_FILTER_PERSIST;
      for (int k = 0; k < CHANNELS; k++) begin
        filt_current[k] = '0;
        persist_cnt[k]  = '0;
        stall_st[k]     = ST_NORMAL;
        stall_tmr[k]    = '0;
      end
      pause_shadow  = 1'b0;
      led_on        = '0;
      led_blink     = '0;
      awaited_results.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i === 1'b1) begin
        case (cfg_idx_i)
          REG_STALL_CURRENT:     cfg_regs.stall_current     = cfg_wdata_i[CUR_W-1:0];
          REG_LED_FAULT_CURRENT: cfg_regs.led_fault_current = cfg_wdata_i[CUR_W-1:0];
          REG_BOOST_TICKS:       cfg_regs.boost_ticks       = cfg_wdata_i[TMR_W-1:0];
          REG_PAUSE_END_TICKS:   cfg_regs.pause_end_ticks   = cfg_wdata_i[TMR_W-1:0];
          REG_FILTER_BAND:       cfg_regs.filter_band       = cfg_wdata_i[CUR_W-1:0];
          REG_FILTER_PERSIST:    cfg_regs.filter_persist    = cfg_wdata_i[PC_W-1:0];
          default: ;
        endcase
      end

      if (result_mon.valid === 1'b1 && result_mon.ready === 1'b1) begin
        if (awaited_results.size() == 0) begin
          $error("result item with no item awaiting it");
          mismatches_o++;
        end else begin
          want = awaited_results.pop_front();
          check_field("speed_out", want.speed_out, result_mon.speed_out);
          check_field("led_on_mask", want.led_on_mask, result_mon.led_on_mask);
          check_field("led_blink_mask", want.led_blink_mask, result_mon.led_blink_mask);
          check_field("stall_state_out", want.stall_state_out, result_mon.stall_state_out);
          check_field("pause_active", want.pause_active, result_mon.pause_active);
        end
      end

      if (item_mon.valid === 1'b1 && item_mon.ready === 1'b1) begin
        it.channel           = item_mon.channel;
        it.raw_current       = item_mon.raw_current;
        it.target_speed      = item_mon.target_speed;
        it.present_speed     = item_mon.present_speed;
        it.channel_commanded = item_mon.channel_commanded;
        it.display_mute      = item_mon.display_mute;
        awaited_results.push_back(predict_tick(it));
      end
      outstanding_o = awaited_results.size();
    end
  end

endmodule

// ===== test/tb_motor_current_speed_stall_guard.sv =====
// Testbench top for the motor current / speed stall guard: clock, reset,
// register writes, directed and random ticks under varied idling, verdict.
// Depends on mcssg_pkg, mcssg_if, the block and mcssg_result_checker.
`timescale 1ns / 1ps

module tb_motor_current_speed_stall_guard;
  import mcssg_pkg::*;

  // Indexes outside the register map; writes to them must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    src_idle_pct;
  int                    sink_stall_pct;
  int                    mismatch_count;
  int                    awaiting_count;

  mcssg_in_if  item_if ();
  mcssg_out_if result_if ();

  motor_current_speed_stall_guard dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (item_if),
    .out_o       (result_if)
  );

  mcssg_result_checker checker_u (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .item_mon      (item_if),
    .result_mon    (result_if),
    .mismatches_o  (mismatch_count),
    .outstanding_o (awaiting_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("motor_current_speed_stall_guard verification failed");
    $finish;
  end

  // Stall the result port at the rate of the current phase
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic item_t mk_item(int ch, int raw, int tgt, int spd, bit cmd, bit mute);
    item_t it;
    it.channel           = CH_W'(ch);
    it.raw_current       = CUR_W'(raw);
    it.target_speed      = SPD_W'(tgt);
    it.present_speed     = SPD_W'(spd);
    it.channel_commanded = cmd;
    it.display_mute      = mute;
    return it;
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.stall_current     = CUR_W'($urandom_range(0, 700));
    c.led_fault_current = CUR_W'($urandom_range(0, 1023));
    c.boost_ticks       = TMR_W'($urandom_range(1, 10));
    c.pause_end_ticks   = TMR_W'($urandom_range(1, 16));
    c.filter_band       = CUR_W'($urandom_range(0, 30));
    c.filter_persist    = PC_W'($urandom_range(0, 4));
    return c;
  endfunction

  // Present speeds clustered at the band edges, near zero and near full speed, or anywhere in range
  function automatic logic [SPD_W-1:0] pick_speed();
    case ($urandom_range(3))
      0:       return SPD_W'($urandom_range(97, 100));
      1:       return $urandom_range(1) ? SPD_W'($urandom_range(43, 47))
                                        : SPD_W'($urandom_range(63, 66));
      2:       return SPD_W'($urandom_range(0, 2));
      default: return SPD_W'($urandom_range(0, 100));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(REG_STALL_CURRENT, CFG_DATA_W'(c.stall_current));
    write_reg(REG_LED_FAULT_CURRENT, CFG_DATA_W'(c.led_fault_current));
    write_reg(REG_BOOST_TICKS, c.boost_ticks);
    write_reg(REG_PAUSE_END_TICKS, c.pause_end_ticks);
    write_reg(REG_FILTER_BAND, CFG_DATA_W'(c.filter_band));
    write_reg(REG_FILTER_PERSIST, CFG_DATA_W'(c.filter_persist));
    write_reg(REG_UNMAPPED_LO, CFG_DATA_W'($urandom));
    write_reg(REG_UNMAPPED_HI, CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one item, idling first at the phase rate, and hold it until taken
  task automatic send_tick(item_t it);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk);
    end
    item_if.valid             <= 1'b1;
    item_if.channel           <= it.channel;
    item_if.raw_current       <= it.raw_current;
    item_if.target_speed      <= it.target_speed;
    item_if.present_speed     <= it.present_speed;
    item_if.channel_commanded <= it.channel_commanded;
    item_if.display_mute      <= it.display_mute;
    do @(posedge clk); while (item_if.ready !== 1'b1);
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk);
    item_if.valid <= 1'b0;
    while (awaiting_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Runs of ticks mostly on one channel around a current level, with some noise
  task automatic run_random(int n);
    item_t           it;
    int              sent;
    int              len;
    int              level;
    int              jit;
    int              raw;
    logic [CH_W-1:0] ch;
    sent = 0;
    while (sent < n) begin
      ch    = CH_W'($urandom_range(CHANNELS - 1));
      len   = $urandom_range(1, 12);
      level = $urandom_range(0, 1023);
      jit   = $urandom_range(0, 12);
      for (int k = 0; k < len && sent < n; k++) begin
        raw = level + int'($urandom_range(0, 2 * jit)) - jit;
        if ($urandom_range(7) == 0) raw = $urandom_range(0, 1023);
        if (raw < 0) raw = 0;
        if (raw > 1023) raw = 1023;
        it.channel           = ($urandom_range(9) == 0) ? CH_W'($urandom_range(3)) : ch;
        it.raw_current       = CUR_W'(raw);
        it.present_speed     = pick_speed();
        case ($urandom_range(3))
          0:       it.target_speed = '0;
          1:       it.target_speed = SPD_W'($urandom_range(98, 100));
          default: it.target_speed = SPD_W'($urandom_range(1, 100));
        endcase
        it.channel_commanded = ($urandom_range(7) != 0);
        it.display_mute      = ($urandom_range(7) == 0);
        send_tick(it);
        sent++;
        if ($urandom_range(49) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    cfg_t c;
    rst_n                     = 1'b0;
    cfg_we                    = 1'b0;
    cfg_idx                   = '0;
    cfg_wdata                 = '0;
    src_idle_pct              = 0;
    sink_stall_pct            = 0;
    item_if.valid             = 1'b0;
    item_if.channel           = '0;
    item_if.raw_current       = '0;
    item_if.target_speed      = '0;
    item_if.present_speed     = '0;
    item_if.channel_commanded = 1'b0;
    item_if.display_mute      = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Reset defaults: filtered current stays at zero, so speeds step down and wrap
    send_tick(mk_item(0, 1023, 50, 0, 1, 0));
    send_tick(mk_item(1, 0, 0, 100, 1, 1));
    send_tick(mk_item(2, 512, 100, 45, 0, 0));
    send_tick(mk_item(3, 1, 98, 65, 1, 0));
    send_tick(mk_item(0, 700, 97, 64, 1, 0));
    send_tick(mk_item(1, 300, 1, 46, 0, 1));
    wait_drained();

    // Immediate filter, low stall level, short boost and pause
    c = '{10'd100, 10'd200, 16'd2, 16'd3, 10'd0, 8'd0};
    apply_config(c);
    send_tick(mk_item(1, 1023, 100, 100, 1, 0));
    send_tick(mk_item(1, 1023, 100, 100, 1, 0));
    send_tick(mk_item(2, 50, 60, 60, 1, 0));
    send_tick(mk_item(1, 1023, 100, 50, 1, 0));
    send_tick(mk_item(3, 0, 10, 0, 1, 0));
    send_tick(mk_item(0, 1023, 100, 99, 1, 1));
    send_tick(mk_item(0, 1023, 100, 99, 0, 0));
    send_tick(mk_item(0, 150, 100, 99, 1, 0));
    send_tick(mk_item(2, 40, 0, 45, 1, 0));
    send_tick(mk_item(3, 1023, 30, 30, 1, 0));
    send_tick(mk_item(0, 0, 100, 100, 1, 0));
    send_tick(mk_item(0, 0, 100, 100, 1, 0));
    send_tick(mk_item(0, 0, 100, 100, 1, 0));
    send_tick(mk_item(2, 200, 64, 64, 1, 0));
    wait_drained();

    // Random phases, each setting its own register values and idling pattern
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          c = '{10'd300, 10'd200, 16'd4, 16'd9, 10'd8, 8'd2};
        end
        1: begin
          src_idle_pct   = 73;
          sink_stall_pct = 0;
          c = '0;
          c.boost_ticks     = 16'd1;
          c.pause_end_ticks = 16'd1;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 73;
          c = random_config();
        end
        3: begin
          src_idle_pct   = 35;
          sink_stall_pct = 35;
          c = '1;
          c.filter_persist = 8'd254;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          c = random_config();
        end
      endcase
      apply_config(c);
      run_random(76);
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && awaiting_count == 0) begin
      $display("motor_current_speed_stall_guard verification clean");
    end else begin
      $display("motor_current_speed_stall_guard verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mcssg_pkg.sv
rtl/core/mcssg_if.sv
rtl/core/mcssg_ram.sv
rtl/core/mcssg_update.sv
rtl/core/motor_current_speed_stall_guard.sv
test/mcssg_result_checker.sv
test/tb_motor_current_speed_stall_guard.sv
